>>> hdl/texture_vram_slot_allocator_assert.svh
// ----------------------------------------------------------------------------
// Texture VRAM slot allocator assertion macros
// Concurrent assertion shorthands shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_VRAM_SLOT_ALLOCATOR_ASSERT_SVH
`define TEXTURE_VRAM_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TVSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TVSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tvsa_pkg.sv
// ----------------------------------------------------------------------------
// Texture VRAM slot allocator package
// VRAM layout constants, size class tables, codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tvsa_pkg;

  localparam int unsigned ScreenWidth = 320;

  localparam int unsigned FirstPage128x32 = 16;
  localparam int unsigned FirstPage64x64  = 18;
  localparam int unsigned FirstPage64x32  = 19;
  localparam int unsigned FirstPage32x32  = 23;
  localparam int unsigned FirstPage16x16  = 26;
  localparam int unsigned FirstPage8x16   = 28;
  localparam int unsigned FirstPageCluts  = 29;
  localparam int unsigned PagesEnd        = 32;
  localparam int unsigned Bpp             = 4;
  localparam int unsigned HighPalRow      = 240;

  localparam int unsigned PageW       = 64;
  localparam int unsigned PageH       = 256;
  localparam int unsigned PagesPerRow = 16;
  localparam int unsigned VramH       = 512;
  localparam int unsigned HwPerTexel  = 16 / Bpp;
  localparam int unsigned HwShift     = $clog2(HwPerTexel);
  localparam int unsigned PageXBits   = $clog2(PageW);

  // Field widths.
  localparam int unsigned TexDimW  = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ClassW   = 3;
  localparam int unsigned VramXW   = 10;
  localparam int unsigned VramYW   = 9;
  localparam int unsigned PalXW    = 10;
  localparam int unsigned PalYW    = 9;
  localparam int unsigned TexOffXW = 8;
  localparam int unsigned TexOffYW = 8;
  localparam int unsigned MaskW    = 5;
  localparam int unsigned UpWW     = 6;
  localparam int unsigned UpHW     = 7;
  localparam int unsigned LogW     = 3;

  typedef enum logic [StatusW-1:0] {
    StPlaced      = 2'd0,
    StSkipped     = 2'd1,
    StUnsupported = 2'd2,
    StFull        = 2'd3
  } status_e;

  typedef enum logic [ClassW-1:0] {
    Cls8x16   = 3'd0,
    Cls16x16  = 3'd1,
    Cls32x32  = 3'd2,
    Cls64x32  = 3'd3,
    Cls64x64  = 3'd4,
    Cls128x32 = 3'd5
  } size_class_e;

  localparam int unsigned NumClasses = 6;

  typedef int unsigned cls_arr_t [NumClasses];

  localparam cls_arr_t ClsAw = '{8, 16, 32, 64, 64, 128};
  localparam cls_arr_t ClsAh = '{16, 16, 32, 32, 64, 32};

  localparam cls_arr_t ClsPage = '{
    FirstPage8x16, FirstPage16x16, FirstPage32x32,
    FirstPage64x32, FirstPage64x64, FirstPage128x32
  };

  localparam cls_arr_t ClsNp = '{
    FirstPageCluts - FirstPage8x16,
    FirstPage8x16 - FirstPage16x16,
    FirstPage16x16 - FirstPage32x32,
    FirstPage32x32 - FirstPage64x32,
    FirstPage64x32 - FirstPage64x64,
    FirstPage64x64 - FirstPage128x32
  };

  // Width of one texture of the class in halfwords.
  localparam cls_arr_t ClsStep = '{
    ClsAw[0] / HwPerTexel, ClsAw[1] / HwPerTexel, ClsAw[2] / HwPerTexel,
    ClsAw[3] / HwPerTexel, ClsAw[4] / HwPerTexel, ClsAw[5] / HwPerTexel
  };

  localparam cls_arr_t ClsStepLog = '{
    $clog2(ClsStep[0]), $clog2(ClsStep[1]), $clog2(ClsStep[2]),
    $clog2(ClsStep[3]), $clog2(ClsStep[4]), $clog2(ClsStep[5])
  };

  localparam cls_arr_t ClsAhLog = '{
    $clog2(ClsAh[0]), $clog2(ClsAh[1]), $clog2(ClsAh[2]),
    $clog2(ClsAh[3]), $clog2(ClsAh[4]), $clog2(ClsAh[5])
  };

  // Slots side by side across all pages of the class. The narrowest class
  // is counted at the row pitch of the 16 texel class.
  localparam cls_arr_t ClsPerRow = '{
    PageW / ClsStep[1] * ClsNp[0], PageW / ClsStep[1] * ClsNp[1],
    PageW / ClsStep[2] * ClsNp[2], PageW / ClsStep[3] * ClsNp[3],
    PageW / ClsStep[4] * ClsNp[4], PageW / ClsStep[5] * ClsNp[5]
  };

  // The smallest class only gets a sixty-fourth of its nominal budget.
  localparam cls_arr_t ClsBudget = '{
    PageH / ClsStep[0] * (PageH / ClsAh[0]) * ClsNp[0] / 64,
    PageH / ClsStep[1] * (PageH / ClsAh[1]) * ClsNp[1],
    PageH / ClsStep[2] * (PageH / ClsAh[2]) * ClsNp[2],
    PageH / ClsStep[3] * (PageH / ClsAh[3]) * ClsNp[3],
    PageH / ClsStep[4] * (PageH / ClsAh[4]) * ClsNp[4],
    PageH / ClsStep[5] * (PageH / ClsAh[5]) * ClsNp[5]
  };

  localparam cls_arr_t ClsFit = '{
    ClsPerRow[0] * ((VramH - ClsPage[0] / PagesPerRow * PageH) / ClsAh[0]),
    ClsPerRow[1] * ((VramH - ClsPage[1] / PagesPerRow * PageH) / ClsAh[1]),
    ClsPerRow[2] * ((VramH - ClsPage[2] / PagesPerRow * PageH) / ClsAh[2]),
    ClsPerRow[3] * ((VramH - ClsPage[3] / PagesPerRow * PageH) / ClsAh[3]),
    ClsPerRow[4] * ((VramH - ClsPage[4] / PagesPerRow * PageH) / ClsAh[4]),
    ClsPerRow[5] * ((VramH - ClsPage[5] / PagesPerRow * PageH) / ClsAh[5])
  };

  localparam cls_arr_t ClsCap = '{
    (ClsBudget[0] < ClsFit[0]) ? ClsBudget[0] : ClsFit[0],
    (ClsBudget[1] < ClsFit[1]) ? ClsBudget[1] : ClsFit[1],
    (ClsBudget[2] < ClsFit[2]) ? ClsBudget[2] : ClsFit[2],
    (ClsBudget[3] < ClsFit[3]) ? ClsBudget[3] : ClsFit[3],
    (ClsBudget[4] < ClsFit[4]) ? ClsBudget[4] : ClsFit[4],
    (ClsBudget[5] < ClsFit[5]) ? ClsBudget[5] : ClsFit[5]
  };

  localparam cls_arr_t ClsRows = '{
    (ClsCap[0] + ClsPerRow[0] - 1) / ClsPerRow[0],
    (ClsCap[1] + ClsPerRow[1] - 1) / ClsPerRow[1],
    (ClsCap[2] + ClsPerRow[2] - 1) / ClsPerRow[2],
    (ClsCap[3] + ClsPerRow[3] - 1) / ClsPerRow[3],
    (ClsCap[4] + ClsPerRow[4] - 1) / ClsPerRow[4],
    (ClsCap[5] + ClsPerRow[5] - 1) / ClsPerRow[5]
  };

  // Palette indexes are handed out from the largest class down.
  localparam cls_arr_t ClsPal0 = '{
    ClsBudget[5] + ClsBudget[4] + ClsBudget[3] + ClsBudget[2] + ClsBudget[1],
    ClsBudget[5] + ClsBudget[4] + ClsBudget[3] + ClsBudget[2],
    ClsBudget[5] + ClsBudget[4] + ClsBudget[3],
    ClsBudget[5] + ClsBudget[4],
    ClsBudget[5],
    0
  };

  localparam int unsigned PalTotal = ClsPal0[0] + ClsBudget[0];

  localparam int unsigned LowPalPerRow  = (PagesEnd - FirstPageCluts) * PageW / (1 << Bpp);
  localparam int unsigned LowPalSlots   = LowPalPerRow * PageH;
  localparam int unsigned LowPalX0      = (FirstPageCluts % PagesPerRow) * PageW;
  localparam int unsigned LowPalY0      = FirstPageCluts / PagesPerRow * PageH;
  localparam int unsigned HighPalPerRow = ScreenWidth * 2 / (1 << Bpp);

  localparam int unsigned RecipShift   = 16;
  localparam int unsigned RecipW       = RecipShift;
  localparam int unsigned LowPalRecip  = ((1 << RecipShift) + LowPalPerRow - 1) / LowPalPerRow;
  localparam int unsigned HighPalRecip = ((1 << RecipShift) + HighPalPerRow - 1) / HighPalPerRow;

  function automatic int unsigned arr_max(cls_arr_t a);
    int unsigned m;
    m = 0;
    for (int k = 0; k < NumClasses; k++) begin
      if (a[k] > m) begin
        m = a[k];
      end
    end
    return m;
  endfunction

  localparam int unsigned SlotW   = $clog2(arr_max(ClsCap) + 1);
  localparam int unsigned ColW    = $clog2(arr_max(ClsPerRow));
  localparam int unsigned RowW    = $clog2(arr_max(ClsRows) + 1);
  localparam int unsigned PalIdxW = $clog2(PalTotal);
  localparam int unsigned ProdW   = PalIdxW + RecipW;

  typedef struct packed {
    logic        skip;
    logic        unsup;
    size_class_e cls;
  } cls_req_t;

  typedef struct packed {
    logic             full;
    logic [SlotW-1:0] slot;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
  } slot_info_t;

  typedef struct packed {
    logic [VramXW-1:0]  page_x;
    logic [VramYW-1:0]  page_y;
    logic [LogW-1:0]    step_log;
    logic [LogW-1:0]    ah_log;
    logic [UpHW-1:0]    ah;
    logic [MaskW-1:0]   mask_x;
    logic [MaskW-1:0]   mask_y;
    logic [PalIdxW-1:0] pal0;
  } cls_const_t;

  typedef struct packed {
    logic [VramXW-1:0]   vram_x;
    logic [VramYW-1:0]   vram_y;
    logic [PalXW-1:0]    palette_x;
    logic [PalYW-1:0]    palette_y;
    logic [TexOffXW-1:0] texel_off_x;
    logic [TexOffYW-1:0] texel_off_y;
    logic [MaskW-1:0]    window_mask_x;
    logic [MaskW-1:0]    window_mask_y;
    logic [UpHW-1:0]     upload_height;
  } place_t;

  function automatic cls_const_t cls_const_at(int unsigned k);
    cls_const_t r;
    r.page_x   = VramXW'((ClsPage[k] % PagesPerRow) * PageW);
    r.page_y   = VramYW'(ClsPage[k] / PagesPerRow * PageH);
    r.step_log = LogW'(ClsStepLog[k]);
    r.ah_log   = LogW'(ClsAhLog[k]);
    r.ah       = UpHW'(ClsAh[k]);
    r.mask_x   = MaskW'(~(ClsAw[k] / 8 - 1));
    r.mask_y   = MaskW'(~(ClsAh[k] / 8 - 1));
    r.pal0     = PalIdxW'(ClsPal0[k]);
    return r;
  endfunction

  function automatic cls_const_t cls_const(size_class_e c);
    cls_const_t r;
    unique case (c)
      Cls8x16:   r = cls_const_at(0);
      Cls16x16:  r = cls_const_at(1);
      Cls32x32:  r = cls_const_at(2);
      Cls64x32:  r = cls_const_at(3);
      Cls64x64:  r = cls_const_at(4);
      Cls128x32: r = cls_const_at(5);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tvsa_classify.sv
// ----------------------------------------------------------------------------
// Size class selection
// Picks the first class that holds the texture; flags skipped and unsupported.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvsa_classify (
  input  logic [tvsa_pkg::TexDimW-1:0] tex_width_i,
  input  logic [tvsa_pkg::TexDimW-1:0] tex_height_i,
  input  logic                         already_loaded_i,
  output tvsa_pkg::cls_req_t           req_o
);
  import tvsa_pkg::*;

  logic [NumClasses-1:0] fits;

  always_comb begin
    for (int k = 0; k < NumClasses; k++) begin
      fits[k] = (tex_width_i <= TexDimW'(ClsAw[k])) && (tex_height_i <= TexDimW'(ClsAh[k]));
    end
  end

  always_comb begin
    req_o.skip  = already_loaded_i;
    req_o.unsup = 1'b0;
    priority if (fits[0]) begin
      req_o.cls = Cls8x16;
    end else if (fits[1]) begin
      req_o.cls = Cls16x16;
    end else if (fits[2]) begin
      req_o.cls = Cls32x32;
    end else if (fits[3]) begin
      req_o.cls = Cls64x32;
    end else if (fits[4]) begin
      req_o.cls = Cls64x64;
    end else if (fits[5]) begin
      req_o.cls = Cls128x32;
    end else begin
      req_o.cls   = Cls8x16;
      req_o.unsup = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tvsa_slot_ctr.sv
// ----------------------------------------------------------------------------
// Per-class slot counters
// Holds the number of slots handed out per class, kept also as column and
// row of the slot grid, and reports the next slot of the selected class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvsa_slot_ctr (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tvsa_pkg::size_class_e cls_i,
  input  logic                  bump_i,
  output tvsa_pkg::slot_info_t  info_o
);
  import tvsa_pkg::*;

  logic [SlotW-1:0]      slot_all [NumClasses];
  logic [ColW-1:0]       col_all  [NumClasses];
  logic [RowW-1:0]       row_all  [NumClasses];
  logic [NumClasses-1:0] full_all;

  for (genvar k = 0; k < NumClasses; k++) begin : g_cls
    localparam int unsigned CntW = $clog2(ClsCap[k] + 1);
    localparam int unsigned CW   = $clog2(ClsPerRow[k]);
    localparam int unsigned RW   = $clog2(ClsRows[k] + 1);

    logic [CntW-1:0] cnt_q, cnt_d;
    logic [CW-1:0]   col_q, col_d;
    logic [RW-1:0]   row_q, row_d;
    logic            sel;

    assign sel = bump_i && (cls_i == size_class_e'(k));

    always_comb begin
      cnt_d = cnt_q;
      col_d = col_q;
      row_d = row_q;
      if (sel) begin
        cnt_d = cnt_q + 1'b1;
        if (col_q == CW'(ClsPerRow[k] - 1)) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q <= '0;
        col_q <= '0;
        row_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        col_q <= col_d;
        row_q <= row_d;
      end
    end

    assign slot_all[k] = SlotW'(cnt_q);
    assign col_all[k]  = ColW'(col_q);
    assign row_all[k]  = RowW'(row_q);
    assign full_all[k] = cnt_q >= CntW'(ClsCap[k]);
  end

  always_comb begin
    info_o = '0;
    for (int k = 0; k < NumClasses; k++) begin
      if (cls_i == size_class_e'(k)) begin
        info_o.full = full_all[k];
        info_o.slot = slot_all[k];
        info_o.col  = col_all[k];
        info_o.row  = row_all[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/tvsa_place.sv
// ----------------------------------------------------------------------------
// Slot placement
// Turns a class and slot into texture, palette and window coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvsa_place (
  input  tvsa_pkg::size_class_e cls_i,
  input  tvsa_pkg::slot_info_t  info_i,
  output tvsa_pkg::place_t      place_o
);
  import tvsa_pkg::*;

  cls_const_t         cc;
  logic [VramXW-1:0]  vx;
  logic [VramYW-1:0]  vy;
  logic [PalIdxW-1:0] idx;
  logic               in_low;
  logic [ProdW-1:0]   lo_prod, hi_prod;
  logic [PalIdxW-1:0] lo_q, lo_rem;
  logic [PalIdxW-1:0] hi_j, hi_q, hi_rem;

  assign cc = cls_const(cls_i);

  assign vx = cc.page_x + (VramXW'(info_i.col) << cc.step_log);
  assign vy = cc.page_y + (VramYW'(info_i.row) << cc.ah_log);

  // Division by the palette row lengths uses a scaled reciprocal; the
  // index range keeps the rounding error below one step.
  assign idx     = cc.pal0 + PalIdxW'(info_i.slot);
  assign in_low  = idx < PalIdxW'(LowPalSlots);
  assign lo_prod = ProdW'(idx) * ProdW'(LowPalRecip);
  assign lo_q    = lo_prod[RecipShift +: PalIdxW];
  assign lo_rem  = idx - lo_q * PalIdxW'(LowPalPerRow);
  assign hi_j    = idx - PalIdxW'(LowPalSlots);
  assign hi_prod = ProdW'(hi_j) * ProdW'(HighPalRecip);
  assign hi_q    = hi_prod[RecipShift +: PalIdxW];
  assign hi_rem  = hi_j - hi_q * PalIdxW'(HighPalPerRow);

  always_comb begin
    place_o.vram_x = vx;
    place_o.vram_y = vy;
    if (in_low) begin
      place_o.palette_x = PalXW'(LowPalX0) + (PalXW'(lo_rem) << Bpp);
      place_o.palette_y = PalYW'(LowPalY0) + PalYW'(lo_q);
    end else begin
      place_o.palette_x = PalXW'(hi_rem) << Bpp;
      place_o.palette_y = PalYW'(HighPalRow) + PalYW'(hi_q);
    end
    place_o.texel_off_x   = TexOffXW'(vx[PageXBits-1:0]) << HwShift;
    place_o.texel_off_y   = vy[TexOffYW-1:0];
    place_o.window_mask_x = cc.mask_x;
    place_o.window_mask_y = cc.mask_y;
    place_o.upload_height = cc.ah;
  end

endmodule

`default_nettype wire

>>> hdl/texture_vram_slot_allocator.sv
// ----------------------------------------------------------------------------
// Texture VRAM slot allocator
// Pipeline: a request is taken into the input register, then its result into the result register.
// Throughput: one request per cycle while out_ready_i is high, set by the input and result registers.
// Reset: all six class slot counters clear to zero; both stages are empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "texture_vram_slot_allocator_assert.svh"

module texture_vram_slot_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tvsa_pkg::TexDimW-1:0]  tex_width_i,
  input  logic [tvsa_pkg::TexDimW-1:0]  tex_height_i,
  input  logic                          already_loaded_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tvsa_pkg::StatusW-1:0]  status_o,
  output logic [tvsa_pkg::ClassW-1:0]   size_class_o,
  output logic [tvsa_pkg::VramXW-1:0]   vram_x_o,
  output logic [tvsa_pkg::VramYW-1:0]   vram_y_o,
  output logic [tvsa_pkg::PalXW-1:0]    palette_x_o,
  output logic [tvsa_pkg::PalYW-1:0]    palette_y_o,
  output logic [tvsa_pkg::TexOffXW-1:0] texel_off_x_o,
  output logic [tvsa_pkg::TexOffYW-1:0] texel_off_y_o,
  output logic [tvsa_pkg::MaskW-1:0]    window_mask_x_o,
  output logic [tvsa_pkg::MaskW-1:0]    window_mask_y_o,
  output logic [tvsa_pkg::UpWW-1:0]     upload_width_o,
  output logic [tvsa_pkg::UpHW-1:0]     upload_height_o
);
  import tvsa_pkg::*;

  logic               in_vld_q, in_vld_d;
  logic [TexDimW-1:0] in_w_q, in_h_q;
  logic               in_loaded_q;
  logic               in_xfer;
  logic               advance;

  cls_req_t   req;
  slot_info_t info;
  place_t     place;
  logic       bump;

  status_e     status_d, status_q;
  size_class_e size_class_d, size_class_q;
  place_t      place_d, place_q;
  logic [UpWW-1:0] upload_width_d, upload_width_q;
  logic        out_vld_q, out_vld_d;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_vld_d   = in_xfer || (in_vld_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_w_q      <= tex_width_i;
      in_h_q      <= tex_height_i;
      in_loaded_q <= already_loaded_i;
    end
  end

  tvsa_classify u_classify (
    .tex_width_i      (in_w_q),
    .tex_height_i     (in_h_q),
    .already_loaded_i (in_loaded_q),
    .req_o            (req)
  );

  tvsa_slot_ctr u_slot_ctr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cls_i  (req.cls),
    .bump_i (bump),
    .info_o (info)
  );

  tvsa_place u_place (
    .cls_i   (req.cls),
    .info_i  (info),
    .place_o (place)
  );

  always_comb begin
    priority if (req.skip) begin
      status_d = StSkipped;
    end else if (req.unsup) begin
      status_d = StUnsupported;
    end else if (info.full) begin
      status_d = StFull;
    end else begin
      status_d = StPlaced;
    end
  end

  assign bump = advance && (status_d == StPlaced);

  always_comb begin
    place_d        = '0;
    upload_width_d = '0;
    size_class_d   = Cls8x16;
    if (status_d == StPlaced) begin
      place_d        = place;
      upload_width_d = in_w_q[HwShift +: UpWW];
      size_class_d   = req.cls;
    end else if (status_d == StFull) begin
      size_class_d = req.cls;
    end
  end

  assign out_vld_d = advance || (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q       <= status_d;
      size_class_q   <= size_class_d;
      place_q        <= place_d;
      upload_width_q <= upload_width_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign size_class_o    = size_class_q;
  assign vram_x_o        = place_q.vram_x;
  assign vram_y_o        = place_q.vram_y;
  assign palette_x_o     = place_q.palette_x;
  assign palette_y_o     = place_q.palette_y;
  assign texel_off_x_o   = place_q.texel_off_x;
  assign texel_off_y_o   = place_q.texel_off_y;
  assign window_mask_x_o = place_q.window_mask_x;
  assign window_mask_y_o = place_q.window_mask_y;
  assign upload_width_o  = upload_width_q;
  assign upload_height_o = place_q.upload_height;

  `TVSA_ASSERT_IMP(a_ready_low_only_when_stuck, clk_i, rst_ni, !in_ready_o,
                   in_vld_q && out_vld_q && !out_ready_i, "input stalled without cause")
  `TVSA_ASSERT_NXT(a_free_output_takes_item, clk_i, rst_ni,
                   in_vld_q && (!out_vld_q || out_ready_i), out_vld_q, "request not moved on")
  `TVSA_ASSERT_IMP(a_palette_aligned, clk_i, rst_ni, out_vld_q && status_q == StPlaced,
                   place_q.palette_x[Bpp-1:0] == '0, "palette column not aligned")
  `TVSA_ASSERT_IMP(a_unplaced_fields_zero, clk_i, rst_ni, out_vld_q && status_q != StPlaced,
                   place_q == '0 && upload_width_q == '0, "unplaced result carries data")

endmodule

`default_nettype wire
